### rtl/trq_pkg.sv
package trq_pkg;

	// Default sizes of the task space and the wait table.
	localparam int NUM_TASKS_DEF  = 64;
	localparam int WAIT_SLOTS_DEF = 64;

	// Fixed widths of the command and result fields.
	localparam int CMD_W     = 2;
	localparam int ID_W      = 6;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 7;
	localparam int COUNT_MAX = 127;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_ENQUEUE  = 2'd0,
		CMD_DEQUEUE  = 2'd1,
		CMD_BLOCK    = 2'd2,
		CMD_COMPLETE = 2'd3
	} cmd_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_DUP   = 3'd1,
		ST_EMPTY = 3'd2,
		ST_FULL  = 3'd3,
		ST_NONE  = 3'd4
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ,
		S_DEQ,
		S_BLOCK,
		S_SCAN,
		S_DRAIN,
		S_CFIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic enq;
		logic deq;
		logic blk_step;
		logic scan_rd;
		logic fin_cmp;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic blk_done;
		logic scan_last;
	} ctl_sts_t;

endpackage

### rtl/trq_ram.sv
module trq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### rtl/trq_ctrl.sv
module trq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [trq_pkg::CMD_W-1:0]  command,
	input  trq_pkg::ctl_sts_t          sts,
	output trq_pkg::ctl_cmd_t          ctl,
	output logic                       busy,
	output logic                       done
);

	import trq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   finish;
	logic   done_q;

	// State register and the result strobe, which follows the finishing step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		finish  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					unique case (cmd_t'(command))
						CMD_ENQUEUE:  state_d = S_ENQ;
						CMD_DEQUEUE:  state_d = S_DEQ;
						CMD_BLOCK:    state_d = S_BLOCK;
						CMD_COMPLETE: state_d = S_SCAN;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_ENQ: begin
				ctl.enq = 1'b1;
				finish  = 1'b1;
				state_d = S_IDLE;
			end
			S_DEQ: begin
				ctl.deq = 1'b1;
				finish  = 1'b1;
				state_d = S_IDLE;
			end
			S_BLOCK: begin
				ctl.blk_step = 1'b1;
				if (sts.blk_done) begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				ctl.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// The last slot read is evaluated in this cycle.
				state_d = S_CFIN;
			end
			S_CFIN: begin
				ctl.fin_cmp = 1'b1;
				finish      = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

### rtl/trq_dpath.sv
module trq_dpath #(
	parameter int NUM_TASKS  = trq_pkg::NUM_TASKS_DEF,
	parameter int WAIT_SLOTS = trq_pkg::WAIT_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  trq_pkg::ctl_cmd_t             ctl,
	output trq_pkg::ctl_sts_t             sts,
	input  logic [trq_pkg::ID_W-1:0]      task_id,
	input  logic [trq_pkg::ID_W-1:0]      dependency_id,
	output logic [trq_pkg::STATUS_W-1:0]  status,
	output logic [trq_pkg::ID_W-1:0]      dequeued_task,
	output logic [trq_pkg::COUNT_W-1:0]   released_count,
	output logic [trq_pkg::COUNT_W-1:0]   queue_count
);

	import trq_pkg::*;

	localparam int TW = $clog2(NUM_TASKS);
	localparam int SW = $clog2(WAIT_SLOTS);
	localparam int CW = $clog2(NUM_TASKS + 1);
	localparam int RW = $clog2(WAIT_SLOTS + 1);
	localparam int ID_VALUES = 2 ** ID_W;

	// Latched command operands.
	logic [TW-1:0] task_q;
	logic [TW-1:0] dep_q;

	// Ready queue pointers, occupancy and membership bits.
	logic [TW-1:0]        head_q;
	logic [TW-1:0]        tail_q;
	logic [CW-1:0]        count_q;
	logic [NUM_TASKS-1:0] flags_q;

	// Wait table occupancy, scan index and evaluation stage.
	logic [WAIT_SLOTS-1:0] valid_q;
	logic [SW-1:0]         idx_q;
	logic                  ev_s1;
	logic [SW-1:0]         slot_s1;
	logic [RW-1:0]         rel_q;

	// Result registers.
	status_t       status_q;
	logic [TW-1:0] deq_q;

	logic [TW-1:0]   red_tbl [ID_VALUES];
	logic [TW-1:0]   fifo_rd;
	logic [2*TW-1:0] pair_rd;
	logic [TW-1:0]   pair_dep;
	logic [TW-1:0]   pair_wtr;
	logic [TW-1:0]   head_nx;
	logic [TW-1:0]   tail_nx;
	logic            fifo_full;
	logic            fifo_empty;
	logic            match;
	logic            push_req;
	logic [TW-1:0]   push_task;
	logic            push_ok;
	logic            pop_ok;
	logic            slot_free;
	logic            idx_last;
	logic            blk_store;

	// Task numbers are reduced modulo the task count through a constant table.
	for (genvar v = 0; v < ID_VALUES; v++) begin : g_red
		assign red_tbl[v] = TW'(v % NUM_TASKS);
	end

	// Ready queue storage: written at the tail, read at the head.
	trq_ram #(
		.WIDTH (TW),
		.DEPTH (NUM_TASKS)
	) u_fifo_ram (
		.clk     (clk),
		.wr_en   (push_ok),
		.wr_addr (tail_q),
		.wr_data (push_task),
		.rd_addr (head_q),
		.rd_data (fifo_rd)
	);

	// Wait table pairs: stored by block, read in slot order by complete.
	trq_ram #(
		.WIDTH (2 * TW),
		.DEPTH (WAIT_SLOTS)
	) u_pair_ram (
		.clk     (clk),
		.wr_en   (blk_store),
		.wr_addr (idx_q),
		.wr_data ({dep_q, task_q}),
		.rd_addr (idx_q),
		.rd_data (pair_rd)
	);

	assign pair_dep = pair_rd[2*TW-1:TW];
	assign pair_wtr = pair_rd[TW-1:0];

	// Pointer wrap and queue limits.
	assign head_nx    = (head_q == TW'(NUM_TASKS - 1)) ? '0 : head_q + 1'b1;
	assign tail_nx    = (tail_q == TW'(NUM_TASKS - 1)) ? '0 : tail_q + 1'b1;
	assign fifo_full  = (count_q == CW'(NUM_TASKS));
	assign fifo_empty = (count_q == '0);

	// A scanned slot releases its waiter when it holds the finished task.
	assign match = ev_s1 && valid_q[slot_s1] && (pair_dep == task_q);

	// Shared push path with the duplicate check.
	assign push_req  = ctl.enq || match;
	assign push_task = ctl.enq ? task_q : pair_wtr;
	assign push_ok   = push_req && !flags_q[push_task] && !fifo_full;
	assign pop_ok    = ctl.deq && !fifo_empty;

	// Free slot search for block.
	assign slot_free = !valid_q[idx_q];
	assign idx_last  = (idx_q == SW'(WAIT_SLOTS - 1));
	assign blk_store = ctl.blk_step && slot_free;

	assign sts.blk_done  = slot_free || idx_last;
	assign sts.scan_last = idx_last;

	// Control state of queue, table and scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			flags_q <= '0;
			valid_q <= '0;
			idx_q   <= '0;
			ev_s1   <= 1'b0;
			rel_q   <= '0;
		end else begin
			ev_s1 <= ctl.scan_rd;
			if (ctl.load) begin
				idx_q <= '0;
			end else if ((ctl.blk_step && !sts.blk_done) || (ctl.scan_rd && !idx_last)) begin
				idx_q <= idx_q + 1'b1;
			end
			if (ctl.load) begin
				rel_q <= '0;
			end else if (match) begin
				rel_q <= rel_q + 1'b1;
			end
			if (push_ok) begin
				tail_q             <= tail_nx;
				count_q            <= count_q + 1'b1;
				flags_q[push_task] <= 1'b1;
			end
			if (pop_ok) begin
				head_q           <= head_nx;
				count_q          <= count_q - 1'b1;
				flags_q[fifo_rd] <= 1'b0;
			end
			if (blk_store) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (match) begin
				valid_q[slot_s1] <= 1'b0;
			end
		end
	end

	// Operands, evaluation slot and result payload.
	always_ff @(posedge clk) begin
		slot_s1 <= idx_q;
		if (ctl.load) begin
			task_q <= red_tbl[task_id];
			dep_q  <= red_tbl[dependency_id];
			deq_q  <= '0;
		end else if (pop_ok) begin
			deq_q <= fifo_rd;
		end
		if (ctl.enq) begin
			status_q <= push_ok ? ST_OK : ST_DUP;
		end else if (ctl.deq) begin
			status_q <= fifo_empty ? ST_EMPTY : ST_OK;
		end else if (ctl.blk_step && sts.blk_done) begin
			status_q <= slot_free ? ST_OK : ST_FULL;
		end else if (ctl.fin_cmp) begin
			status_q <= (rel_q == '0) ? ST_NONE : ST_OK;
		end
	end

	assign status = status_q;

	// Result fields sized to the fixed port widths, counts saturating.
	if (TW >= ID_W) begin : g_deq_cut
		assign dequeued_task = deq_q[ID_W-1:0];
	end else begin : g_deq_ext
		assign dequeued_task = ID_W'(deq_q);
	end

	if (CW > COUNT_W) begin : g_qc_sat
		assign queue_count = (count_q > CW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
			: count_q[COUNT_W-1:0];
	end else begin : g_qc_ext
		assign queue_count = COUNT_W'(count_q);
	end

	if (RW > COUNT_W) begin : g_rel_sat
		assign released_count = (rel_q > RW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
			: rel_q[COUNT_W-1:0];
	end else begin : g_rel_ext
		assign released_count = COUNT_W'(rel_q);
	end

endmodule

### rtl/task_ready_queue_with_wait_table.sv
// Channel   Handshake          Fields
// command   start / busy       command, task_id, dependency_id
// result    done (strobe)      status, dequeued_task, released_count, queue_count
//
// An item is taken when start is high and busy is low; its result appears
// with done for one cycle, and the next item may be taken in that cycle.
// Enqueue and dequeue do their work in S_ENQ or S_DEQ, then return to idle.
// Block walks the wait table one slot a cycle until it finds a free slot or
// reaches the last slot. Complete reads every slot of the wait table RAM once,
// then passes through S_DRAIN and S_CFIN. Reset clears all queue and table
// state at once; the result side cannot stall.
module task_ready_queue_with_wait_table #(
	parameter int NUM_TASKS  = trq_pkg::NUM_TASKS_DEF,
	parameter int WAIT_SLOTS = trq_pkg::WAIT_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [trq_pkg::CMD_W-1:0]     command,
	input  logic [trq_pkg::ID_W-1:0]      task_id,
	input  logic [trq_pkg::ID_W-1:0]      dependency_id,
	output logic                          done,
	output logic [trq_pkg::STATUS_W-1:0]  status,
	output logic [trq_pkg::ID_W-1:0]      dequeued_task,
	output logic [trq_pkg::COUNT_W-1:0]   released_count,
	output logic [trq_pkg::COUNT_W-1:0]   queue_count
);

	import trq_pkg::*;

	ctl_cmd_t ctl;
	ctl_sts_t sts;

	// Sequencer.
	trq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.sts     (sts),
		.ctl     (ctl),
		.busy    (busy),
		.done    (done)
	);

	// Queue, wait table and result registers.
	trq_dpath #(
		.NUM_TASKS  (NUM_TASKS),
		.WAIT_SLOTS (WAIT_SLOTS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.task_id        (task_id),
		.dependency_id  (dependency_id),
		.status         (status),
		.dequeued_task  (dequeued_task),
		.released_count (released_count),
		.queue_count    (queue_count)
	);

	// A taken item always sets busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item taken without entering a busy cycle");

	// A result only follows a busy cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// An empty dequeue leaves the queue empty and returns no task.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_EMPTY)) |-> ((queue_count == '0) && (dequeued_task == '0)))
		else $error("empty dequeue with non-empty queue or a task");

	// Occupancy never exceeds the number of tasks.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((NUM_TASKS > COUNT_MAX) || (queue_count <= COUNT_W'(NUM_TASKS))))
		else $error("queue occupancy beyond the task count");

endmodule

### tb/task_ready_queue_with_wait_table_test.sv
module task_ready_queue_with_wait_table_test;

	import trq_pkg::*;

	localparam int TASKS        = NUM_TASKS_DEF;
	localparam int SLOTS        = WAIT_SLOTS_DEF;
	localparam int RANDOM_ITEMS = 2000;
	localparam int DRAIN_CYCLES = WAIT_SLOTS_DEF + 4;

	// One expected result of the scheduler.
	typedef struct {
		status_t            status;
		logic [ID_W-1:0]    popped;
		logic [COUNT_W-1:0] released;
		logic [COUNT_W-1:0] occupancy;
	} sched_result_t;

	// Shadow of the scheduler state and the results still owed by the block.
	class sched_scoreboard;
		bit [ID_W-1:0]    ready_ring [TASKS];
		bit [ID_W-1:0]    ring_head;
		bit [ID_W-1:0]    ring_tail;
		int               ready_count;
		bit               in_queue [TASKS];
		bit               slot_used [SLOTS];
		bit [ID_W-1:0]    slot_dep [SLOTS];
		bit [ID_W-1:0]    slot_waiter [SLOTS];
		sched_result_t    owed_results [$];
		int               errors;

		// Pushes a task unless it is queued already or the ring is full; returns 1 when pushed.
		function bit push_ready(bit [ID_W-1:0] tid);
			if (in_queue[tid] || ready_count >= TASKS)
				return 1'b0;
			ready_ring[ring_tail] = tid;
			ring_tail++;
			ready_count++;
			in_queue[tid] = 1'b1;
			return 1'b1;
		endfunction

		// Works out the result of an accepted item and updates the shadow state.
		function void note_item(cmd_t cmd, bit [ID_W-1:0] tid, bit [ID_W-1:0] dep);
			sched_result_t r;
			int freed;
			bit placed;
			r.status = ST_OK;
			r.popped = '0;
			freed = 0;
			placed = 1'b0;
			case (cmd)
				CMD_ENQUEUE: begin
					if (!push_ready(tid))
						r.status = ST_DUP;
				end
				CMD_DEQUEUE: begin
					if (ready_count == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.popped = ready_ring[ring_head];
						ring_head++;
						ready_count--;
						in_queue[r.popped] = 1'b0;
					end
				end
				CMD_BLOCK: begin
					// The lowest free slot takes the pair.
					for (int i = 0; i < SLOTS; i++) begin
						if (!placed && !slot_used[i]) begin
							slot_used[i] = 1'b1;
							slot_dep[i] = dep;
							slot_waiter[i] = tid;
							placed = 1'b1;
						end
					end
					if (!placed)
						r.status = ST_FULL;
				end
				default: begin
					// Release every waiter on the finished task in slot order.
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_used[i] && slot_dep[i] == tid) begin
							slot_used[i] = 1'b0;
							freed++;
							void'(push_ready(slot_waiter[i]));
						end
					end
					if (freed == 0)
						r.status = ST_NONE;
				end
			endcase
			r.released = COUNT_W'((freed > COUNT_MAX) ? COUNT_MAX : freed);
			r.occupancy = COUNT_W'((ready_count > COUNT_MAX) ? COUNT_MAX : ready_count);
			owed_results.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		// Compares a result from the block with the oldest owed result.
		task check_result(logic [STATUS_W-1:0] st, logic [ID_W-1:0] popped,
				logic [COUNT_W-1:0] released, logic [COUNT_W-1:0] occupancy);
			sched_result_t r;
			if (owed_results.size() == 0) begin
				report_mismatch("result with no item outstanding");
			end else begin
				r = owed_results.pop_front();
				if (st !== r.status)
					report_mismatch($sformatf("status %0d, expected %0d", st, r.status));
				if (popped !== r.popped)
					report_mismatch($sformatf("dequeued_task %0d, expected %0d",
						popped, r.popped));
				if (released !== r.released)
					report_mismatch($sformatf("released_count %0d, expected %0d",
						released, r.released));
				if (occupancy !== r.occupancy)
					report_mismatch($sformatf("queue_count %0d, expected %0d",
						occupancy, r.occupancy));
			end
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [CMD_W-1:0]    command;
	logic [ID_W-1:0]     task_id;
	logic [ID_W-1:0]     dependency_id;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     dequeued_task;
	logic [COUNT_W-1:0]  released_count;
	logic [COUNT_W-1:0]  queue_count;

	sched_scoreboard sb = new;
	int burst_left;
	int profile;

	task_ready_queue_with_wait_table i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.task_id        (task_id),
		.dependency_id  (dependency_id),
		.done           (done),
		.status         (status),
		.dequeued_task  (dequeued_task),
		.released_count (released_count),
		.queue_count    (queue_count)
	);

	always #5 clk = ~clk;

	// Results are checked before the item taken at the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(status, dequeued_task, released_count, queue_count);
			if (start && !busy)
				sb.note_item(cmd_t'(command), task_id, dependency_id);
		end
	end

	// Presents one item and returns at the edge that takes it; idles between bursts.
	task send_item(cmd_t cmd, logic [ID_W-1:0] tid, logic [ID_W-1:0] dep);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 80) : $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120)
				: $urandom_range(1, 10);
		end
		start <= 1'b1;
		command <= cmd;
		task_id <= tid;
		dependency_id <= dep;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		burst_left--;
	endtask

	// Task numbers lean on a small set so that completes find their waiters.
	function logic [ID_W-1:0] pick_id();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return ID_W'($urandom_range(0, 7));
		else if (roll == 5)
			return $urandom_range(0, 1) ? '1 : '0;
		return ID_W'($urandom_range(0, TASKS - 1));
	endfunction

	// Each profile weights the commands to build up or run down queue and table.
	function cmd_t pick_command();
		int roll;
		roll = $urandom_range(0, 99);
		case (profile)
			0: return roll < 30 ? CMD_ENQUEUE : roll < 60 ? CMD_DEQUEUE
				: roll < 85 ? CMD_BLOCK : CMD_COMPLETE;
			1: return roll < 25 ? CMD_ENQUEUE : roll < 35 ? CMD_DEQUEUE
				: roll < 90 ? CMD_BLOCK : CMD_COMPLETE;
			2: return roll < 10 ? CMD_ENQUEUE : roll < 50 ? CMD_DEQUEUE
				: roll < 60 ? CMD_BLOCK : CMD_COMPLETE;
			default: return roll < 70 ? CMD_ENQUEUE : roll < 80 ? CMD_DEQUEUE
				: roll < 90 ? CMD_BLOCK : CMD_COMPLETE;
		endcase
	endfunction

	initial begin
		int phase_left;
		arst_n <= 1'b0;
		start <= 1'b0;
		command <= CMD_ENQUEUE;
		task_id <= '0;
		dependency_id <= '0;
		burst_left = 0;
		profile = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty queue, duplicates, repeated pairs and waiters already queued.
		send_item(CMD_DEQUEUE, '1, '1);
		send_item(CMD_COMPLETE, '0, '0);
		send_item(CMD_ENQUEUE, '0, '1);
		send_item(CMD_ENQUEUE, '1, '0);
		send_item(CMD_ENQUEUE, '1, '0);
		send_item(CMD_BLOCK, 6'd5, '1);
		send_item(CMD_BLOCK, 6'd5, '1);
		send_item(CMD_BLOCK, '0, '0);
		send_item(CMD_COMPLETE, '1, '0);
		send_item(CMD_COMPLETE, '1, '0);
		send_item(CMD_DEQUEUE, '0, '0);
		send_item(CMD_DEQUEUE, '0, '0);
		send_item(CMD_BLOCK, '1, '0);
		send_item(CMD_ENQUEUE, '1, '1);
		send_item(CMD_COMPLETE, '0, '1);
		send_item(CMD_DEQUEUE, '1, '1);
		send_item(CMD_DEQUEUE, '1, '1);
		send_item(CMD_DEQUEUE, '1, '1);
		send_item(CMD_DEQUEUE, '1, '1);
		send_item(CMD_BLOCK, 6'd42, 6'd21);
		send_item(CMD_COMPLETE, 6'd21, 6'd42);
		send_item(CMD_ENQUEUE, 6'd21, 6'd42);
		send_item(CMD_DEQUEUE, 6'd42, 6'd21);

		// Fill the wait table past its capacity with random pairs.
		for (int i = 0; i < SLOTS + 6; i++)
			send_item(CMD_BLOCK, pick_id(), pick_id());

		// Random part, changing the command mix from phase to phase.
		phase_left = 0;
		for (int i = 0; i < RANDOM_ITEMS - SLOTS - 6; i++) begin
			if (phase_left == 0) begin
				profile = $urandom_range(0, 3);
				phase_left = $urandom_range(50, 250);
			end
			phase_left--;
			send_item(pick_command(), pick_id(), pick_id());
		end
		start <= 1'b0;

		// Wait for every owed result, then for any stray one.
		while (sb.owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("task_ready_queue_with_wait_table_test passed");
		end else begin
			$display("task_ready_queue_with_wait_table_test failed");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#20000000;
		$display("task_ready_queue_with_wait_table_test failed");
		$finish;
	end

endmodule

### filelist.f
rtl/trq_pkg.sv
rtl/trq_ram.sv
rtl/trq_ctrl.sv
rtl/trq_dpath.sv
rtl/task_ready_queue_with_wait_table.sv
tb/task_ready_queue_with_wait_table_test.sv
